// ----- hdl/dehist_pkg.sv -----
// Shared types and codes of the detector event histogrammer.
package dehist_pkg;

  localparam int unsigned HIST_ADDR_BITS = 18;

  typedef enum logic [1:0] {
    OP_EVENT = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } opcode_e;

  typedef enum logic [2:0] {
    OUT_NEUTRON   = 3'd0,
    OUT_GHOST     = 3'd1,
    OUT_TRIGGER   = 3'd2,
    OUT_TRIG_BAD  = 3'd3,
    OUT_READ      = 3'd4,
    OUT_CLEARED   = 3'd5
  } outcome_e;

  typedef enum logic [2:0] {
    SEL_POS    = 3'd0,
    SEL_AMP    = 3'd1,
    SEL_CHAN   = 3'd2,
    SEL_TUBE   = 3'd3,
    SEL_TRIG   = 3'd4,
    SEL_EVENTS = 3'd5
  } store_sel_e;

  localparam logic CFG_OLD_EIGHT_BIT = 1'b0;
  localparam logic CFG_STRIP_SIXTEEN = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ISSUE,
    ST_FINISH
  } state_e;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_READ,
    CMD_BUMP,
    CMD_WIPE
  } store_cmd_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] word_low;
    logic [15:0] word_mid;
    logic [15:0] word_high;
    logic [1:0]  module_number;
    logic        buffer_start;
    logic [2:0]  store_select;
    logic [7:0]  read_row;
    logic [9:0]  read_column;
  } in_item_t;

  typedef struct packed {
    outcome_e    outcome;
    logic [7:0]  channel;
    logic [9:0]  position;
    logic [9:0]  amplitude;
    logic [7:0]  tube_index;
    logic [3:0]  trigger_source;
    logic [20:0] trigger_data;
    logic [47:0] read_value;
  } out_item_t;

  typedef struct packed {
    logic        is_trig;
    logic [3:0]  src;
    logic [20:0] data;
    logic        src_ok;
    logic        ghost;
    logic [7:0]  chan;
    logic [9:0]  pos;
    logic [9:0]  amp;
    logic [7:0]  tube;
    logic        chan_ok;
    logic        pos_ok;
    logic        amp_ok;
    logic        tube_ok;
  } decode_t;

  typedef struct packed {
    store_cmd_e                kind;
    logic [HIST_ADDR_BITS-1:0] pos_addr;
    logic [HIST_ADDR_BITS-1:0] amp_addr;
    logic [7:0]                chan_idx;
    logic [7:0]                tube_idx;
    logic                      pos_en;
    logic                      amp_en;
    logic                      chan_en;
    logic                      tube_en;
  } store_cmd_t;

endpackage

// ----- hdl/detector_event_histogrammer.sv -----
// Top level: sequencer, trigger and event counters, config registers, result register.
//
//   channel  handshake               payload
//   in       in_valid_i / in_ready_o  in_item_i  (dehist_pkg::in_item_t)
//   out      out_valid_o / out_ready_i out_item_o (dehist_pkg::out_item_t)
//   cfg      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// An event or read steps through accept, memory read, then write-back and result,
// as the registered memory read comes ahead of the increment.
// A clear sweeps the histogram memories one entry a cycle, all CHANNELS*BINS entries
// (262144 at defaults), then gives its result; the same pass runs after reset.
// A result still waiting in the output register holds the sequencer in its last state once
// the next result is ready, until the waiting one leaves; configuration writes are always taken.
module detector_event_histogrammer #(
  parameter int unsigned CHANNELS        = 256,
  parameter int unsigned BINS            = 1024,
  parameter int unsigned COUNT_BITS      = 32,
  parameter int unsigned TRIGGER_SOURCES = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  dehist_pkg::in_item_t  in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output dehist_pkg::out_item_t out_item_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic                  cfg_index_i,
  input  logic [31:0]           cfg_data_i
);

  localparam int unsigned DEPTH = CHANNELS * BINS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(CHANNELS);
  localparam int unsigned BW    = $clog2(BINS);
  localparam int unsigned TSW   = $clog2(TRIGGER_SOURCES);

  dehist_pkg::state_e     state_q, state_d;
  dehist_pkg::in_item_t   item_q;
  dehist_pkg::decode_t    dec, dec_q;
  dehist_pkg::store_cmd_t cmd;
  dehist_pkg::out_item_t  out_q, result;

  logic [31:0]           old_mask_q, strip_mask_q;
  logic                  seen_q, clr_pending_q, out_valid_q;
  logic [AW-1:0]         clr_cnt_q;
  logic [COUNT_BITS-1:0] trig_cnt_q [TRIGGER_SOURCES];
  logic [47:0]           events_q;
  logic [COUNT_BITS-1:0] pos_rd, amp_rd, chan_rd, tube_rd;
  logic                  accept, finish, clr_last;
  logic                  row_ok, col_ok, trow_ok;
  logic [AW-1:0]         rd_addr, pos_addr, amp_addr;

  assign accept   = in_valid_i && in_ready_o;
  assign finish   = (state_q == dehist_pkg::ST_FINISH) && (!out_valid_q || out_ready_i);
  assign clr_last = clr_cnt_q == AW'(DEPTH - 1);
  assign cfg_ready_o = 1'b1;

  dehist_decode #(
    .CHANNELS(CHANNELS), .BINS(BINS), .TRIGGER_SOURCES(TRIGGER_SOURCES)
  ) u_decode (
    .item_i(item_q), .old_mask_i(old_mask_q), .strip_mask_i(strip_mask_q),
    .seen_i(seen_q), .dec_o(dec)
  );

  dehist_stores #(
    .CHANNELS(CHANNELS), .BINS(BINS), .COUNT_BITS(COUNT_BITS)
  ) u_stores (
    .clk_i, .rst_ni, .cmd_i(cmd),
    .pos_rd_o(pos_rd), .amp_rd_o(amp_rd), .chan_rd_o(chan_rd), .tube_rd_o(tube_rd)
  );

  assign row_ok  = {1'b0, item_q.read_row} < 9'(CHANNELS);
  assign col_ok  = {1'b0, item_q.read_column} < 11'(BINS);
  assign trow_ok = {1'b0, item_q.read_row} < 9'(TRIGGER_SOURCES);
  assign rd_addr  = AW'(item_q.read_row[CW-1:0]) * AW'(BINS) + AW'(item_q.read_column[BW-1:0]);
  assign pos_addr = AW'(dec.chan[CW-1:0]) * AW'(BINS) + AW'(dec.pos[BW-1:0]);
  assign amp_addr = AW'(dec.chan[CW-1:0]) * AW'(BINS) + AW'(dec.amp[BW-1:0]);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dehist_pkg::ST_CLEAR: begin
        if (clr_last) state_d = clr_pending_q ? dehist_pkg::ST_FINISH : dehist_pkg::ST_IDLE;
      end
      dehist_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_item_i.opcode)
            dehist_pkg::OP_EVENT, dehist_pkg::OP_READ: state_d = dehist_pkg::ST_ISSUE;
            dehist_pkg::OP_CLEAR: state_d = dehist_pkg::ST_CLEAR;
            default: state_d = dehist_pkg::ST_IDLE;
          endcase
        end
      end
      dehist_pkg::ST_ISSUE: state_d = dehist_pkg::ST_FINISH;
      dehist_pkg::ST_FINISH: begin
        if (finish) state_d = dehist_pkg::ST_IDLE;
      end
      default: state_d = dehist_pkg::ST_IDLE;
    endcase
  end

  // outputs: handshake and memory command
  always_comb begin
    in_ready_o = (state_q == dehist_pkg::ST_IDLE);
    cmd = '0;
    cmd.kind = dehist_pkg::CMD_NONE;
    case (state_q)
      dehist_pkg::ST_CLEAR: begin
        cmd.kind     = dehist_pkg::CMD_WIPE;
        cmd.pos_addr = dehist_pkg::HIST_ADDR_BITS'(clr_cnt_q);
        cmd.amp_addr = dehist_pkg::HIST_ADDR_BITS'(clr_cnt_q);
        cmd.chan_idx = 8'(clr_cnt_q[CW-1:0]);
        cmd.tube_idx = 8'(clr_cnt_q[CW-1:0]);
        cmd.chan_en  = clr_cnt_q < AW'(CHANNELS);
        cmd.tube_en  = clr_cnt_q < AW'(CHANNELS);
      end
      dehist_pkg::ST_ISSUE: begin
        if (item_q.opcode == dehist_pkg::OP_READ) begin
          cmd.kind     = dehist_pkg::CMD_READ;
          cmd.pos_addr = dehist_pkg::HIST_ADDR_BITS'(rd_addr);
          cmd.amp_addr = dehist_pkg::HIST_ADDR_BITS'(rd_addr);
          cmd.chan_idx = item_q.read_row;
          cmd.tube_idx = item_q.read_row;
        end else if (!dec.is_trig && !dec.ghost) begin
          cmd.kind     = dehist_pkg::CMD_BUMP;
          cmd.pos_addr = dehist_pkg::HIST_ADDR_BITS'(pos_addr);
          cmd.amp_addr = dehist_pkg::HIST_ADDR_BITS'(amp_addr);
          cmd.chan_idx = dec.chan;
          cmd.tube_idx = dec.tube;
          cmd.pos_en   = dec.chan_ok && dec.pos_ok;
          cmd.amp_en   = dec.chan_ok && dec.amp_ok;
          cmd.chan_en  = dec.chan_ok;
          cmd.tube_en  = dec.tube_ok;
        end
      end
      default: ;
    endcase
  end

  // result word
  always_comb begin
    result = '0;
    case (item_q.opcode)
      dehist_pkg::OP_READ: begin
        result.outcome = dehist_pkg::OUT_READ;
        case (item_q.store_select)
          dehist_pkg::SEL_POS:    if (row_ok && col_ok) result.read_value = 48'(pos_rd);
          dehist_pkg::SEL_AMP:    if (row_ok && col_ok) result.read_value = 48'(amp_rd);
          dehist_pkg::SEL_CHAN:   if (row_ok) result.read_value = 48'(chan_rd);
          dehist_pkg::SEL_TUBE:   if (row_ok) result.read_value = 48'(tube_rd);
          dehist_pkg::SEL_TRIG:
            if (trow_ok) result.read_value = 48'(trig_cnt_q[item_q.read_row[TSW-1:0]]);
          dehist_pkg::SEL_EVENTS: result.read_value = events_q;
          default: result.read_value = '0;
        endcase
      end
      dehist_pkg::OP_CLEAR: result.outcome = dehist_pkg::OUT_CLEARED;
      default: begin
        if (dec_q.is_trig) begin
          result.outcome = dec_q.src_ok ? dehist_pkg::OUT_TRIGGER : dehist_pkg::OUT_TRIG_BAD;
          result.trigger_source = dec_q.src;
          result.trigger_data   = dec_q.data;
        end else begin
          result.outcome   = dec_q.ghost ? dehist_pkg::OUT_GHOST : dehist_pkg::OUT_NEUTRON;
          result.channel   = dec_q.chan;
          result.position  = dec_q.pos;
          result.amplitude = dec_q.amp;
          result.tube_index = dec_q.ghost ? 8'd0 : dec_q.tube;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= dehist_pkg::ST_CLEAR;
      clr_cnt_q     <= '0;
      clr_pending_q <= 1'b0;
      seen_q        <= 1'b0;
      out_valid_q   <= 1'b0;
      old_mask_q    <= '0;
      strip_mask_q  <= '0;
      events_q      <= '0;
      for (int i = 0; i < int'(TRIGGER_SOURCES); i++) trig_cnt_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == dehist_pkg::CFG_OLD_EIGHT_BIT) old_mask_q <= cfg_data_i;
        else strip_mask_q <= cfg_data_i;
      end
      if (state_q == dehist_pkg::ST_CLEAR) clr_cnt_q <= clr_last ? '0 : clr_cnt_q + 1'b1;
      if (accept && in_item_i.opcode == dehist_pkg::OP_CLEAR) begin
        clr_pending_q <= 1'b1;
        events_q      <= '0;
        for (int i = 0; i < int'(TRIGGER_SOURCES); i++) trig_cnt_q[i] <= '0;
      end
      if (state_q == dehist_pkg::ST_ISSUE && item_q.opcode == dehist_pkg::OP_EVENT) begin
        if (dec.is_trig) begin
          if (item_q.buffer_start) seen_q <= 1'b0;
          if (dec.src_ok && trig_cnt_q[dec.src[TSW-1:0]] != '1)
            trig_cnt_q[dec.src[TSW-1:0]] <= trig_cnt_q[dec.src[TSW-1:0]] + 1'b1;
        end else begin
          seen_q <= 1'b1;
          if (!dec.ghost && events_q != '1) events_q <= events_q + 1'b1;
        end
      end
      if (finish) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) item_q <= in_item_i;
    if (state_q == dehist_pkg::ST_ISSUE) dec_q <= dec;
    if (finish) out_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ----- hdl/dehist_decode.sv -----
// Event word decode: trigger fields, channel, position, amplitude, tube, ghost.
module dehist_decode #(
  parameter int unsigned CHANNELS        = 256,
  parameter int unsigned BINS            = 1024,
  parameter int unsigned TRIGGER_SOURCES = 8
) (
  input  dehist_pkg::in_item_t item_i,
  input  logic [31:0]          old_mask_i,
  input  logic [31:0]          strip_mask_i,
  input  logic                 seen_i,
  output dehist_pkg::decode_t  dec_o
);

  logic [15:0] wm, wh;
  logic [4:0]  sub;
  logic [7:0]  local_idx, chan;
  logic [9:0]  pos_raw, amp_raw, pos, amp;
  logic        old8, first;

  assign wm        = item_i.word_mid;
  assign wh        = item_i.word_high;
  assign sub       = {item_i.module_number, wh[14:12]};
  assign local_idx = {2'b00, wh[14:12], 3'b000} + {3'b000, wh[11:7]};
  assign chan      = local_idx + {item_i.module_number, 6'b000000};
  assign pos_raw   = wm[12:3];
  assign amp_raw   = {wh[6:0], wm[15:13]};
  assign old8      = old_mask_i[sub];
  assign pos       = old8 ? (pos_raw >> 2) : pos_raw;
  assign amp       = old8 ? (amp_raw >> 2) : amp_raw;
  assign first     = item_i.buffer_start | ~seen_i;

  always_comb begin
    dec_o         = '0;
    dec_o.is_trig = wh[15];
    dec_o.src     = wh[11:8];
    dec_o.data    = {wh[7:0], wm[15:3]};
    dec_o.src_ok  = {1'b0, wh[11:8]} < 5'(TRIGGER_SOURCES);
    dec_o.chan    = chan;
    dec_o.pos     = pos;
    dec_o.amp     = amp;
    dec_o.ghost   = first && (local_idx == 8'd0) && (pos == 10'd0) && (amp == 10'd0);
    dec_o.tube    = strip_mask_i[sub] ? {chan[6:0], pos[9]} : chan;
    dec_o.chan_ok = {1'b0, chan} < 9'(CHANNELS);
    dec_o.tube_ok = {1'b0, dec_o.tube} < 9'(CHANNELS);
    dec_o.pos_ok  = {1'b0, pos} < 11'(BINS);
    dec_o.amp_ok  = {1'b0, amp} < 11'(BINS);
  end

endmodule

// ----- hdl/dehist_stores.sv -----
// Histogram and total memories with read, read-modify-write increment and wipe.
module dehist_stores #(
  parameter int unsigned CHANNELS   = 256,
  parameter int unsigned BINS       = 1024,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dehist_pkg::store_cmd_t cmd_i,
  output logic [COUNT_BITS-1:0]  pos_rd_o,
  output logic [COUNT_BITS-1:0]  amp_rd_o,
  output logic [COUNT_BITS-1:0]  chan_rd_o,
  output logic [COUNT_BITS-1:0]  tube_rd_o
);

  localparam int unsigned DEPTH = CHANNELS * BINS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(CHANNELS);

  logic [COUNT_BITS-1:0] pos_mem  [DEPTH];
  logic [COUNT_BITS-1:0] amp_mem  [DEPTH];
  logic [COUNT_BITS-1:0] chan_mem [CHANNELS];
  logic [COUNT_BITS-1:0] tube_mem [CHANNELS];

  dehist_pkg::store_cmd_t cmd_q;
  logic [COUNT_BITS-1:0]  pos_rd_q, amp_rd_q, chan_rd_q, tube_rd_q;
  logic                   rd_en;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    sat_inc = (v == '1) ? v : v + 1'b1;
  endfunction

  assign rd_en = (cmd_i.kind == dehist_pkg::CMD_READ) || (cmd_i.kind == dehist_pkg::CMD_BUMP);

  // command is registered so the increment sees the registered read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q.kind <= dehist_pkg::CMD_NONE;
      cmd_q.pos_addr <= '0;
      cmd_q.amp_addr <= '0;
      cmd_q.chan_idx <= '0;
      cmd_q.tube_idx <= '0;
      cmd_q.pos_en <= 1'b0;
      cmd_q.amp_en <= 1'b0;
      cmd_q.chan_en <= 1'b0;
      cmd_q.tube_en <= 1'b0;
    end else begin
      cmd_q <= cmd_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      pos_rd_q  <= pos_mem[cmd_i.pos_addr[AW-1:0]];
      amp_rd_q  <= amp_mem[cmd_i.amp_addr[AW-1:0]];
      chan_rd_q <= chan_mem[cmd_i.chan_idx[CW-1:0]];
      tube_rd_q <= tube_mem[cmd_i.tube_idx[CW-1:0]];
    end
    if (cmd_i.kind == dehist_pkg::CMD_WIPE) begin
      pos_mem[cmd_i.pos_addr[AW-1:0]] <= '0;
      amp_mem[cmd_i.amp_addr[AW-1:0]] <= '0;
      if (cmd_i.chan_en) chan_mem[cmd_i.chan_idx[CW-1:0]] <= '0;
      if (cmd_i.tube_en) tube_mem[cmd_i.tube_idx[CW-1:0]] <= '0;
    end else if (cmd_q.kind == dehist_pkg::CMD_BUMP) begin
      if (cmd_q.pos_en)  pos_mem[cmd_q.pos_addr[AW-1:0]]  <= sat_inc(pos_rd_q);
      if (cmd_q.amp_en)  amp_mem[cmd_q.amp_addr[AW-1:0]]  <= sat_inc(amp_rd_q);
      if (cmd_q.chan_en) chan_mem[cmd_q.chan_idx[CW-1:0]] <= sat_inc(chan_rd_q);
      if (cmd_q.tube_en) tube_mem[cmd_q.tube_idx[CW-1:0]] <= sat_inc(tube_rd_q);
    end
  end

  assign pos_rd_o  = pos_rd_q;
  assign amp_rd_o  = amp_rd_q;
  assign chan_rd_o = chan_rd_q;
  assign tube_rd_o = tube_rd_q;

endmodule
